/* hw/rtl/line_segment_rect_clipper_defines.svh */
// Assertion macros shared by the clipper RTL.
`ifndef LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH

// Checked only while the block is out of reset.
`define LSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lsrc_pkg.sv */
// Types, widths and constants of the line segment clipper.
package lsrc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int NBND        = 4;
  localparam int DW          = COORD_BITS + 1;      // deltas, p and q
  localparam int RW          = DW + 1;              // divider remainder
  localparam int QW          = FRAC_BITS + 1;       // quotient bits below saturation
  localparam int T0W         = FRAC_BITS + 1;       // t0 and t1, range [0, 1]
  localparam int TW          = FRAC_BITS + 3;       // signed, saturated quotient
  localparam int PW          = T0W + 1 + DW;        // t times delta
  localparam int CW          = DW + 1;              // start plus offset
  localparam int DIV_SPS     = 3;
  localparam int DIV_STAGES  = (QW + DIV_SPS - 1) / DIV_SPS;
  localparam int ADDR_W      = 4;
  localparam int ITEM_W      = 4 * COORD_BITS + 8;
  localparam int TDATA_W     = ((ITEM_W + 7) / 8) * 8;

  localparam logic [T0W-1:0] T_ONE = T0W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
  } cfg_t;

  typedef struct packed {
    logic pz;    // p is zero
    logic pneg;  // p is negative
    logic qneg;  // q is negative
    logic neg;   // quotient is negative
    logic sat;   // |q| >= 2|p|, quotient above one
  } bnd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic [7:0]                   color;
    bnd_t [NBND-1:0]              bnd;
  } item_t;

endpackage

/* hw/rtl/lsrc_cfg.sv */
// Clip rectangle registers behind the configuration port.
module lsrc_cfg
  import lsrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  reg_idx_t idx;
  logic     wr;
  logic signed [COORD_BITS-1:0] rd;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left   <= '0;
      cfg.top    <= '0;
      cfg.right  <= COORD_MAX;
      cfg.bottom <= COORD_MAX;
    end else if (wr) begin
      unique case (idx)
        REG_LEFT:   cfg.left   <= pwdata[COORD_BITS-1:0];
        REG_TOP:    cfg.top    <= pwdata[COORD_BITS-1:0];
        REG_RIGHT:  cfg.right  <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM: cfg.bottom <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT:   rd = cfg.left;
      REG_TOP:    rd = cfg.top;
      REG_RIGHT:  rd = cfg.right;
      REG_BOTTOM: rd = cfg.bottom;
      default:    rd = '0;
    endcase
  end

  assign prdata = 32'(rd);

endmodule

/* hw/rtl/lsrc_div.sv */
// Pipelined restoring divider: floor(a * 2^FRAC_BITS / b) for a < 2b.
module lsrc_div
  import lsrc_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  output logic [QW-1:0] quo
);

  logic [RW-1:0] r_st [DIV_STAGES];
  logic [DW-1:0] b_st [DIV_STAGES];
  logic [QW-1:0] q_st [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [RW-1:0] r_src;
    logic [DW-1:0] b_src;
    logic [QW-1:0] q_src;
    logic [RW-1:0] r_nx;
    logic [QW-1:0] q_nx;

    if (s == 0) begin : g_first
      assign r_src = RW'(a);
      assign b_src = b;
      assign q_src = '0;
    end else begin : g_rest
      assign r_src = r_st[s-1];
      assign b_src = b_st[s-1];
      assign q_src = q_st[s-1];
    end

    // Each step yields one quotient bit, most significant first.
    always_comb begin
      r_nx = r_src;
      q_nx = q_src;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (s * DIV_SPS + j < QW) begin
          if (r_nx >= RW'(b_src)) begin
            r_nx = r_nx - RW'(b_src);
            q_nx = {q_nx[QW-2:0], 1'b1};
          end else begin
            q_nx = {q_nx[QW-2:0], 1'b0};
          end
          r_nx = {r_nx[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_st[s] <= r_nx;
        b_st[s] <= b_src;
        q_st[s] <= q_nx;
      end
    end
  end

  assign quo = q_st[DIV_STAGES-1];

endmodule

/* hw/rtl/line_segment_rect_clipper.sv */
// Liang-Barsky line segment clipper, top level.
//
//  channel   | direction | contents
//  s_*       | in        | segment request: endpoints and color
//  m_*       | out       | clipped segment, visible flag in m_tuser
//  APB       | in        | clip rectangle registers
//
// One segment per clock while the output is not stalled; the pipeline has 5 + DIV_STAGES
// register stages (11 with 16 fraction bits). The depth is set by the four pipelined
// dividers, up to three quotient bits per stage.
// All stages advance together whenever the output register is empty or taken.
// Synchronous reset clears the valid bits; the rectangle resets to 0..32767.
`include "line_segment_rect_clipper_defines.svh"
module line_segment_rect_clipper
  import lsrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [TDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, out_color
  output logic [TDATA_W-1:0] m_tdata,
  // visible
  output logic               m_tuser,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int C = COORD_BITS;

  cfg_t cfg;
  logic en;

  assign pready   = 1'b1;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  lsrc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  // Input register.
  logic v1;
  logic signed [C-1:0] sx1, sy1, ex1, ey1;
  logic [7:0] col1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= s_tdata[C-1:0];
      sy1  <= s_tdata[2*C-1:C];
      ex1  <= s_tdata[3*C-1:2*C];
      ey1  <= s_tdata[4*C-1:3*C];
      col1 <= s_tdata[4*C+7:4*C];
    end
  end

  // p and q for the four boundaries: left, right, top, bottom.
  logic signed [DW-1:0] dx1, dy1;
  logic signed [DW-1:0] p1 [NBND];
  logic signed [DW-1:0] q1 [NBND];
  logic [DW-1:0] pa1 [NBND];
  logic [DW-1:0] qa1 [NBND];
  item_t it1;

  always_comb begin
    dx1   = DW'(ex1) - DW'(sx1);
    dy1   = DW'(ey1) - DW'(sy1);
    p1[0] = -dx1;  q1[0] = DW'(sx1) - DW'(cfg.left);
    p1[1] = dx1;   q1[1] = DW'(cfg.right) - DW'(sx1);
    p1[2] = -dy1;  q1[2] = DW'(sy1) - DW'(cfg.top);
    p1[3] = dy1;   q1[3] = DW'(cfg.bottom) - DW'(sy1);
    it1.sx    = sx1;
    it1.sy    = sy1;
    it1.dx    = dx1;
    it1.dy    = dy1;
    it1.color = col1;
    for (int i = 0; i < NBND; i++) begin
      pa1[i] = p1[i][DW-1] ? DW'(-p1[i]) : DW'(p1[i]);
      qa1[i] = q1[i][DW-1] ? DW'(-q1[i]) : DW'(q1[i]);
      it1.bnd[i].pz   = (p1[i] == '0);
      it1.bnd[i].pneg = p1[i][DW-1];
      it1.bnd[i].qneg = q1[i][DW-1];
      it1.bnd[i].neg  = p1[i][DW-1] ^ q1[i][DW-1];
      it1.bnd[i].sat  = {1'b0, qa1[i]} >= {pa1[i], 1'b0};
    end
  end

  logic v2;
  item_t it2;
  logic [DW-1:0] pa2 [NBND];
  logic [DW-1:0] qa2 [NBND];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2 <= it1;
      for (int i = 0; i < NBND; i++) begin
        pa2[i] <= pa1[i];
        qa2[i] <= qa1[i];
      end
    end
  end

  // Dividers, one per boundary, with the item carried alongside.
  logic [QW-1:0] quo [NBND];

  for (genvar i = 0; i < NBND; i++) begin : g_div
    lsrc_div u_div (.clk, .en, .a(qa2[i]), .b(pa2[i]), .quo(quo[i]));
  end

  item_t side [DIV_STAGES];
  logic [DIV_STAGES-1:0] side_v;

  always_ff @(posedge clk) begin
    if (rst) side_v <= '0;
    else if (en) side_v <= {side_v[DIV_STAGES-2:0], v2};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= it2;
      for (int k = 1; k < DIV_STAGES; k++) side[k] <= side[k-1];
    end
  end

  // Entry and exit parameters, boundaries in order.
  item_t itd;
  logic ok_n;
  logic [T0W-1:0] t0_n, t1_n;
  logic [T0W-1:0] mag [NBND];
  logic signed [TW-1:0] tq [NBND];

  assign itd = side[DIV_STAGES-1];

  always_comb begin
    ok_n = 1'b1;
    t0_n = '0;
    t1_n = T_ONE;
    for (int i = 0; i < NBND; i++) begin
      // Quotients above one all behave alike, so they saturate just past it.
      mag[i] = (itd.bnd[i].sat || (T0W'(quo[i]) > T_ONE)) ? T_ONE + 1'b1 : T0W'(quo[i]);
      tq[i]  = itd.bnd[i].neg ? -TW'(mag[i]) : TW'(mag[i]);
      if (ok_n) begin
        if (itd.bnd[i].pz) begin
          if (itd.bnd[i].qneg) ok_n = 1'b0;
        end else if (itd.bnd[i].pneg) begin
          if (tq[i] > $signed(TW'(t1_n))) ok_n = 1'b0;
          else if (tq[i] > $signed(TW'(t0_n))) t0_n = tq[i][T0W-1:0];
        end else begin
          if (tq[i] < $signed(TW'(t0_n))) ok_n = 1'b0;
          else if (tq[i] < $signed(TW'(t1_n))) t1_n = tq[i][T0W-1:0];
        end
      end
    end
  end

  logic vt, okt;
  logic [T0W-1:0] t0t, t1t;
  logic signed [C-1:0] sxt, syt;
  logic signed [DW-1:0] dxt, dyt;
  logic [7:0] colt;

  always_ff @(posedge clk) begin
    if (rst) vt <= 1'b0;
    else if (en) vt <= side_v[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okt  <= ok_n;
      t0t  <= t0_n;
      t1t  <= t1_n;
      sxt  <= itd.sx;
      syt  <= itd.sy;
      dxt  <= itd.dx;
      dyt  <= itd.dy;
      colt <= itd.color;
    end
  end

  // Products t times delta.
  logic vm, okm;
  logic signed [PW-1:0] pax, pay, pbx, pby;
  logic signed [C-1:0] sxm, sym;
  logic [7:0] colm;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= vt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pax  <= $signed({1'b0, t0t}) * dxt;
      pay  <= $signed({1'b0, t0t}) * dyt;
      pbx  <= $signed({1'b0, t1t}) * dxt;
      pby  <= $signed({1'b0, t1t}) * dyt;
      okm  <= okt;
      sxm  <= sxt;
      sym  <= syt;
      colm <= colt;
    end
  end

  // Start plus offset truncated toward zero, raised to lo, then lowered to hi.
  function automatic logic [C-1:0] along(logic signed [C-1:0] base,
                                         logic signed [PW-1:0] prod,
                                         logic signed [C-1:0] lo,
                                         logic signed [C-1:0] hi);
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] off;
    logic signed [CW-1:0] v;
    biased = prod + (prod[PW-1] ? $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                : $signed(PW'(0)));
    off    = biased >>> FRAC_BITS;
    v      = CW'(base) + off[CW-1:0];
    if (v < CW'(lo)) v = CW'(lo);
    if (v > CW'(hi)) v = CW'(hi);
    return v[C-1:0];
  endfunction

  logic [C-1:0] ax, ay, bx, by;
  logic [7:0] colo;
  logic viso;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      viso <= okm;
      colo <= colm;
      ax   <= okm ? along(sxm, pax, cfg.left, cfg.right) : '0;
      ay   <= okm ? along(sym, pay, cfg.top, cfg.bottom) : '0;
      bx   <= okm ? along(sxm, pbx, cfg.left, cfg.right) : '0;
      by   <= okm ? along(sym, pby, cfg.top, cfg.bottom) : '0;
    end
  end

  assign m_tdata = TDATA_W'({colo, by, bx, ay, ax});
  assign m_tuser = viso;

  `LSRC_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_tvalid, "output valid after reset")
  `LSRC_ASSERT(a_t_order, vt && okt |-> (t0t <= t1t) && (t1t <= T_ONE), "t0 above t1")
  `LSRC_ASSERT(a_reject_zero, m_tvalid && !m_tuser |-> m_tdata[4*C-1:0] == '0, "rejected not zero")
  `LSRC_ASSERT(a_stall_holds, vt && !en |=> vt && $stable(t0t) && $stable(t1t), "stall lost item")

endmodule

/* sim/line_segment_rect_clipper_checker.sv */
// Checker for the line segment clipper: predicts every clipped segment and compares.
`timescale 1ns / 100ps
module line_segment_rect_clipper_checker
  import lsrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tuser,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 seen_visible,
  output int                 seen_rejected
);

  typedef struct packed {
    logic                  visible;
    logic [TDATA_W-1:0]    data;
  } clip_result_t;

  clip_result_t expected_segments[$];
  longint rect_left, rect_top, rect_right, rect_bottom;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Division truncating toward zero regardless of operand signs.
  function automatic longint div_trunc(longint a, longint b);
    longint qa;
    qa = (a < 0 ? -a : a) / (b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -qa : qa;
  endfunction

  function automatic clip_result_t clip_segment(logic [TDATA_W-1:0] d);
    clip_result_t r;
    longint sx, sy, ex, ey, dx, dy, t0, t1, t, ax, ay, bx, by;
    longint p[4];
    longint q[4];
    bit ok;
    sx = longint'($signed(d[15:0]));
    sy = longint'($signed(d[31:16]));
    ex = longint'($signed(d[47:32]));
    ey = longint'($signed(d[63:48]));
    dx = ex - sx;
    dy = ey - sy;
    p[0] = -dx; q[0] = sx - rect_left;
    p[1] = dx;  q[1] = rect_right - sx;
    p[2] = -dy; q[2] = sy - rect_top;
    p[3] = dy;  q[3] = rect_bottom - sy;
    t0 = 0;
    t1 = 65536;
    ok = 1;
    for (int i = 0; i < 4 && ok; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) ok = 0;
      end else begin
        t = div_trunc(q[i] * 65536, p[i]);
        if (p[i] < 0) begin
          if (t > t1) ok = 0;
          else if (t > t0) t0 = clamp_to(t, 0, 65536);
        end else begin
          if (t < t0) ok = 0;
          else if (t < t1) t1 = clamp_to(t, 0, 65536);
        end
      end
    end
    r = '0;
    r.visible = ok;
    r.data[71:64] = d[71:64];
    if (ok) begin
      ax = clamp_to(sx + div_trunc(t0 * dx, 65536), rect_left, rect_right);
      ay = clamp_to(sy + div_trunc(t0 * dy, 65536), rect_top, rect_bottom);
      bx = clamp_to(sx + div_trunc(t1 * dx, 65536), rect_left, rect_right);
      by = clamp_to(sy + div_trunc(t1 * dy, 65536), rect_top, rect_bottom);
      r.data[15:0] = ax[15:0];
      r.data[31:16] = ay[15:0];
      r.data[47:32] = bx[15:0];
      r.data[63:48] = by[15:0];
    end
    return r;
  endfunction

  assign pending = expected_segments.size();

  always @(posedge clk) begin
    clip_result_t want;
    if (rst) begin
      rect_left <= 0; rect_top <= 0; rect_right <= 32767; rect_bottom <= 32767;
      fail_count <= 0;
      seen_visible <= 0;
      seen_rejected <= 0;
      expected_segments.delete();
    end else begin
      // The predictor sees the rectangle as it stood before this edge.
      if (s_tvalid && s_tready) expected_segments = {expected_segments, clip_segment(s_tdata)};
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LEFT:   rect_left   <= longint'($signed(pwdata[15:0]));
          REG_TOP:    rect_top    <= longint'($signed(pwdata[15:0]));
          REG_RIGHT:  rect_right  <= longint'($signed(pwdata[15:0]));
          REG_BOTTOM: rect_bottom <= longint'($signed(pwdata[15:0]));
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (m_tuser) seen_visible <= seen_visible + 1;
        else seen_rejected <= seen_rejected + 1;
        if (expected_segments.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h user %b", m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_segments.pop_front();
          if (want.visible !== m_tuser || want.data !== m_tdata) begin
            if (fail_count < 10)
              $display("mismatch: expected vis %b data %h, got vis %b data %h",
                       want.visible, want.data, m_tuser, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/line_segment_rect_clipper_tb.sv */
// Testbench top for the line segment clipper: stimulus, rectangle setup and verdict.
`timescale 1ns / 100ps
module line_segment_rect_clipper_tb;
  import lsrc_pkg::*;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tuser;
  logic [TDATA_W-1:0] s_tdata = '0, m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending, seen_visible, seen_rejected;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycle_count = 0;
  int segments_sent = 0;
  logic signed [15:0] rl, rt, rr, rb;

  localparam longint CYCLE_LIMIT = 400000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  line_segment_rect_clipper dut (.*);

  line_segment_rect_clipper_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("line_segment_rect_clipper test failed");
      $finish;
    end
  end

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Drops the request valid; called at a falling edge once a request was taken.
  task automatic stop_sending();
    s_tvalid <= 0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic signed [15:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= {{16{v[15]}}, v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_rect(logic signed [15:0] l, logic signed [15:0] t,
                          logic signed [15:0] r, logic signed [15:0] b);
    // Let the pipeline drain completely before touching the rectangle.
    stop_sending();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    rl = l; rt = t; rr = r; rb = b;
  endtask

  task automatic send_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                              logic [15:0] ey, logic [7:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {ey, ex, sy, sx} | (TDATA_W'(color) << 64);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    segments_sent++;
  endtask

  // Coordinate near the rectangle so that most segments cross a boundary.
  function automatic logic [15:0] near(logic signed [15:0] lo, logic signed [15:0] hi);
    int span, v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    span = int'(hi) - int'(lo);
    if (span < 0) span = -span;
    v = int'(lo) - span / 2 + int'($urandom_range(2 * span + 2));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_batch(int n);
    logic [15:0] x0, y0;
    repeat (n) begin
      x0 = near(rl, rr); y0 = near(rt, rb);
      if ($urandom_range(19) == 0) send_segment(x0, y0, x0, y0, 8'($urandom));
      else send_segment(x0, y0, near(rl, rr), near(rt, rb), 8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    rl = 0; rt = 0; rr = 32767; rb = 32767;

    // Directed: reset rectangle, extremes, degenerate points, axis-parallel lines.
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 8'hff);
    send_segment(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 8'h00);
    send_segment(16'd5, 16'd5, 16'd5, 16'd5, 8'h5a);
    send_segment(16'hfffb, 16'd5, 16'hfffb, 16'd5, 8'ha5);
    send_segment(16'h8000, 16'd100, 16'h7fff, 16'd100, 8'h01);
    send_segment(16'd100, 16'h8000, 16'd100, 16'h7fff, 8'h80);
    send_segment(16'hffff, 16'd10, 16'hffff, 16'd20, 8'h11);
    set_rect(-100, -50, 100, 50);
    send_segment(16'hff00, 16'd0, 16'd256, 16'd0, 8'h22);
    send_segment(16'hff00, 16'hff00, 16'd256, 16'd256, 8'h33);
    send_segment(16'd0, 16'd0, 16'd10, 16'd10, 8'h44);
    send_segment(16'd200, 16'd200, 16'd300, 16'd300, 8'h55);
    send_segment(16'hff00, 16'd60, 16'd256, 16'd60, 8'h66);
    send_segment(16'd150, 16'hff9c, 16'hff6a, 16'd100, 8'h77);
    set_rect(10, 10, 5, 20);  // empty rectangle
    send_segment(16'd0, 16'd0, 16'd20, 16'd20, 8'h88);
    send_segment(16'd7, 16'd15, 16'd7, 16'd15, 8'h99);
    set_rect(-32768, -32768, 32767, 32767);
    send_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 8'haa);
    send_segment(16'h1234, 16'hfedc, 16'h1234, 16'hfedc, 8'hbb);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (phase)
        0: set_rect(0, 0, 32767, 32767);
        1: set_rect(-200, -150, 300, 250);
        2: set_rect(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        3: set_rect(-32768, -32768, 32767, 32767);
        4: set_rect(7, 7, 7, 7);
        5: set_rect(-32768, 100, -32000, 32767);
        6: set_rect(0, 0, 1, 1);
        default: set_rect(-1000, -1000, 1000, 1000);
      endcase
      random_batch(90);
      // Hold off until every outstanding result has arrived, then resume.
      stop_sending();
      while (pending != 0) @(negedge clk);
      random_batch(90);
    end

    send_idle_pct = 0;
    stop_sending();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("sent %0d segments over 11 rectangles and four idle mixes", segments_sent);
    $display("results: %0d visible, %0d rejected", seen_visible, seen_rejected);
    if (fail_count == 0 && pending == 0) begin
      $display("line_segment_rect_clipper test passed");
    end else begin
      $display("line_segment_rect_clipper test failed");
    end
    $finish;
  end

endmodule
